// File: sv/gsbp_pkg.sv
// shared types, codes and constants of the gif stream block parser
package gsbp_pkg;

   // request: one byte of the file
   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_byte;
      logic       last_byte;
   } req_type;

   // result: one item per byte
   typedef struct packed {
      logic [3:0]  kind;
      logic [15:0] field_a;
      logic [15:0] field_b;
      logic [15:0] field_c;
      logic [15:0] field_d;
      logic [23:0] color;
      logic [7:0]  packed_flags;
      logic [7:0]  aux_a;
      logic [7:0]  aux_b;
      logic        is_89a;
      logic [1:0]  status;
   } rsp_type;

   // parse phases
   typedef enum logic [4:0] {
      PH_SIG     = 5'd0,
      PH_SCREEN  = 5'd1,
      PH_GCT     = 5'd2,
      PH_BLOCK   = 5'd3,
      PH_IDESC   = 5'd4,
      PH_LCT     = 5'd5,
      PH_CODESZ  = 5'd6,
      PH_DSIZE   = 5'd7,
      PH_DATA    = 5'd8,
      PH_LABEL   = 5'd9,
      PH_GCE     = 5'd10,
      PH_PTSIZE  = 5'd11,
      PH_APPSIZE = 5'd12,
      PH_HDRSKIP = 5'd13,
      PH_SUBSIZE = 5'd14,
      PH_SUBSKIP = 5'd15,
      PH_FIN     = 5'd16,
      PH_ERR     = 5'd17,
      PH_TRUNC   = 5'd18
   } phase_type;

   // result kinds
   localparam logic [3:0] KIND_NONE      = 4'd0;
   localparam logic [3:0] KIND_SCREEN    = 4'd1;
   localparam logic [3:0] KIND_GLOBAL    = 4'd2;
   localparam logic [3:0] KIND_IMAGE     = 4'd3;
   localparam logic [3:0] KIND_CODE_SIZE = 4'd4;
   localparam logic [3:0] KIND_DATA      = 4'd5;
   localparam logic [3:0] KIND_IMAGE_END = 4'd6;
   localparam logic [3:0] KIND_GRAPHIC   = 4'd7;
   localparam logic [3:0] KIND_LOCAL     = 4'd8;

   // status codes
   localparam logic [1:0] ST_RUNNING  = 2'd0;
   localparam logic [1:0] ST_FINISHED = 2'd1;
   localparam logic [1:0] ST_FORMAT   = 2'd2;
   localparam logic [1:0] ST_TRUNC    = 2'd3;

   // block separators and extension labels
   localparam logic [7:0] SEP_IMAGE     = 8'h2C;
   localparam logic [7:0] SEP_EXT       = 8'h21;
   localparam logic [7:0] SEP_TRAILER   = 8'h3B;
   localparam logic [7:0] LBL_GRAPHIC   = 8'hF9;
   localparam logic [7:0] LBL_COMMENT   = 8'hFE;
   localparam logic [7:0] LBL_PLAINTEXT = 8'h01;
   localparam logic [7:0] LBL_APP       = 8'hFF;

   // fixed block sizes
   localparam logic [7:0] SIZE_GRAPHIC   = 8'd4;
   localparam logic [7:0] SIZE_PLAINTEXT = 8'd12;
   localparam logic [7:0] SIZE_APP       = 8'd11;

   // number of bytes kept from a descriptor
   localparam int FIELD_DEPTH = 9;

endpackage

// File: sv/gsbp_in_stage.sv
// input register of the gif stream block parser
module gsbp_in_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  gsbp_pkg::req_type req_data,
   input  logic             advance,
   output logic             item_valid,
   output gsbp_pkg::req_type item
);
   import gsbp_pkg::*;

   logic    valid_ff, valid_in;
   req_type item_ff;

   // hold while the held request cannot move on
   assign req_stall = valid_ff & ~advance;
   assign valid_in  = req_stall ? valid_ff : req_valid;

   // control register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload register
   always_ff @(posedge clock) begin
      if (!req_stall) begin
         item_ff <= req_data;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// File: sv/gsbp_parser.sv
// parse state and the per-byte decode of the gif block structure
module gsbp_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  gsbp_pkg::req_type item,
   output gsbp_pkg::rsp_type result
);
   import gsbp_pkg::*;

   localparam int FbIdxW = $clog2(FIELD_DEPTH);

   phase_type   phase_ff, phase_in;
   logic [3:0]  pos_ff, pos_in;
   logic [8:0]  entry_ff, entry_in;
   logic [8:0]  table_ff, table_in;
   logic [7:0]  left_ff, left_in;
   logic [15:0] rgb_ff, rgb_in;
   logic        ver_ff, ver_in;
   logic [7:0]  fb_ff [FIELD_DEPTH];

   // state seen by this byte, after an optional restart
   phase_type   cur_phase;
   logic [3:0]  cur_pos;
   logic [8:0]  cur_entry;
   logic [8:0]  cur_table;
   logic [7:0]  cur_left;
   logic [15:0] cur_rgb;
   logic        cur_ver;

   logic              fb_we;
   logic [FbIdxW-1:0] fb_idx;
   logic [7:0]        b;
   logic [8:0]        entry_inc;
   logic [7:0]        left_dec;
   logic [7:0]        sig_char;

   assign b = item.data_byte;

   always_comb begin
      if (item.first_byte) begin
         cur_phase = PH_SIG;
         cur_pos   = '0;
         cur_entry = '0;
         cur_table = '0;
         cur_left  = '0;
         cur_rgb   = '0;
         cur_ver   = 1'b0;
      end else begin
         cur_phase = phase_ff;
         cur_pos   = pos_ff;
         cur_entry = entry_ff;
         cur_table = table_ff;
         cur_left  = left_ff;
         cur_rgb   = rgb_ff;
         cur_ver   = ver_ff;
      end
   end

   // expected signature character, with 87a at the version position
   always_comb begin
      case (cur_pos)
         4'd0:    sig_char = 8'h47;
         4'd1:    sig_char = 8'h49;
         4'd2:    sig_char = 8'h46;
         4'd3:    sig_char = 8'h38;
         4'd4:    sig_char = 8'h37;
         4'd5:    sig_char = 8'h61;
         default: sig_char = 8'h00;
      endcase
   end

   assign entry_inc = cur_entry + 9'd1;
   assign left_dec  = cur_left - 8'd1;

   // next state and result of one byte
   always_comb begin
      phase_in = cur_phase;
      pos_in   = cur_pos;
      entry_in = cur_entry;
      table_in = cur_table;
      left_in  = cur_left;
      rgb_in   = cur_rgb;
      ver_in   = cur_ver;
      fb_we    = 1'b0;
      fb_idx   = '0;
      result   = '0;

      case (cur_phase)
         PH_SIG: begin
            if (cur_pos == 4'd4 && b == 8'h39) begin
               ver_in = 1'b1;
               pos_in = cur_pos + 4'd1;
            end else if (cur_pos > 4'd5 || b != sig_char) begin
               phase_in = PH_ERR;
            end else begin
               pos_in = cur_pos + 4'd1;
            end
            if (phase_in != PH_ERR && cur_pos == 4'd5) begin
               pos_in   = '0;
               phase_in = PH_SCREEN;
            end
         end
         PH_SCREEN: begin
            fb_we  = 1'b1;
            fb_idx = FbIdxW'(cur_pos[2:0]);
            if (cur_pos < 4'd6) begin
               pos_in = cur_pos + 4'd1;
            end else begin
               result.kind         = KIND_SCREEN;
               result.field_a      = {fb_ff[1], fb_ff[0]};
               result.field_b      = {fb_ff[3], fb_ff[2]};
               result.packed_flags = fb_ff[4];
               result.aux_a        = fb_ff[5];
               result.aux_b        = b;
               pos_in   = '0;
               entry_in = '0;
               if (fb_ff[4][7]) begin
                  table_in = 9'd2 << fb_ff[4][2:0];
                  phase_in = PH_GCT;
               end else begin
                  table_in = '0;
                  phase_in = PH_BLOCK;
               end
            end
         end
         PH_GCT, PH_LCT: begin
            if (cur_pos == 4'd0) begin
               rgb_in = {b, 8'h00};
               pos_in = 4'd1;
            end else if (cur_pos == 4'd1) begin
               rgb_in = {cur_rgb[15:8], b};
               pos_in = 4'd2;
            end else begin
               result.kind    = (cur_phase == PH_GCT) ? KIND_GLOBAL : KIND_LOCAL;
               result.field_a = {7'd0, cur_entry};
               result.color   = {cur_rgb, b};
               pos_in   = '0;
               entry_in = entry_inc;
               if (entry_inc >= cur_table) begin
                  phase_in = (cur_phase == PH_GCT) ? PH_BLOCK : PH_CODESZ;
               end
            end
         end
         PH_BLOCK: begin
            pos_in = '0;
            if (b == SEP_IMAGE) begin
               phase_in = PH_IDESC;
            end else if (b == SEP_EXT) begin
               phase_in = PH_LABEL;
            end else if (b == SEP_TRAILER && item.last_byte) begin
               phase_in = PH_FIN;
            end else begin
               phase_in = PH_ERR;
            end
         end
         PH_IDESC: begin
            fb_we  = 1'b1;
            fb_idx = (cur_pos < 4'd9) ? FbIdxW'(cur_pos) : FbIdxW'(8);
            if (cur_pos < 4'd8) begin
               pos_in = cur_pos + 4'd1;
            end else begin
               result.kind         = KIND_IMAGE;
               result.field_a      = {fb_ff[1], fb_ff[0]};
               result.field_b      = {fb_ff[3], fb_ff[2]};
               result.field_c      = {fb_ff[5], fb_ff[4]};
               result.field_d      = {fb_ff[7], fb_ff[6]};
               result.packed_flags = b;
               pos_in   = '0;
               entry_in = '0;
               if (b[7]) begin
                  table_in = 9'd2 << b[2:0];
                  phase_in = PH_LCT;
               end else begin
                  table_in = '0;
                  phase_in = PH_CODESZ;
               end
            end
         end
         PH_CODESZ: begin
            result.kind    = KIND_CODE_SIZE;
            result.field_a = {8'd0, b};
            phase_in       = PH_DSIZE;
         end
         PH_DSIZE: begin
            if (b == 8'd0) begin
               result.kind = KIND_IMAGE_END;
               phase_in    = PH_BLOCK;
            end else begin
               left_in  = b;
               phase_in = PH_DATA;
            end
         end
         PH_DATA: begin
            result.kind    = KIND_DATA;
            result.field_a = {8'd0, b};
            left_in        = left_dec;
            if (left_dec == 8'd0) begin
               phase_in = PH_DSIZE;
            end
         end
         PH_LABEL: begin
            pos_in = '0;
            if (b == LBL_GRAPHIC) begin
               phase_in = PH_GCE;
            end else if (b == LBL_COMMENT) begin
               phase_in = PH_SUBSIZE;
            end else if (b == LBL_PLAINTEXT) begin
               phase_in = PH_PTSIZE;
            end else if (b == LBL_APP) begin
               phase_in = PH_APPSIZE;
            end else begin
               phase_in = PH_ERR;
            end
         end
         PH_GCE: begin
            if (cur_pos == 4'd0 && b != SIZE_GRAPHIC) begin
               phase_in = PH_ERR;
            end else if (cur_pos < 4'd5) begin
               fb_we  = 1'b1;
               fb_idx = FbIdxW'(cur_pos);
               pos_in = cur_pos + 4'd1;
            end else if (b != 8'd0) begin
               phase_in = PH_ERR;
            end else begin
               result.kind         = KIND_GRAPHIC;
               result.field_a      = {fb_ff[3], fb_ff[2]};
               result.packed_flags = fb_ff[1];
               result.aux_a        = fb_ff[4];
               pos_in   = '0;
               phase_in = PH_BLOCK;
            end
         end
         PH_PTSIZE, PH_APPSIZE: begin
            if (b != ((cur_phase == PH_PTSIZE) ? SIZE_PLAINTEXT : SIZE_APP)) begin
               phase_in = PH_ERR;
            end else begin
               left_in  = b;
               phase_in = PH_HDRSKIP;
            end
         end
         PH_HDRSKIP, PH_SUBSKIP: begin
            left_in = left_dec;
            if (left_dec == 8'd0) begin
               phase_in = PH_SUBSIZE;
            end
         end
         PH_SUBSIZE: begin
            if (b == 8'd0) begin
               phase_in = PH_BLOCK;
            end else begin
               left_in  = b;
               phase_in = PH_SUBSKIP;
            end
         end
         default: begin
         end
      endcase

      // status, with truncation on a last byte mid-file
      if (phase_in == PH_FIN) begin
         result.status = ST_FINISHED;
      end else if (phase_in == PH_ERR) begin
         result.status = ST_FORMAT;
      end else if (phase_in == PH_TRUNC) begin
         result.status = ST_TRUNC;
      end else if (item.last_byte) begin
         phase_in      = PH_TRUNC;
         result.status = ST_TRUNC;
      end else begin
         result.status = ST_RUNNING;
      end
      result.is_89a = ver_in;
   end

   // parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SIG;
         pos_ff   <= '0;
         entry_ff <= '0;
         table_ff <= '0;
         left_ff  <= '0;
         rgb_ff   <= '0;
         ver_ff   <= 1'b0;
      end else if (advance) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         entry_ff <= entry_in;
         table_ff <= table_in;
         left_ff  <= left_in;
         rgb_ff   <= rgb_in;
         ver_ff   <= ver_in;
      end
   end

   // descriptor byte store, always written before it is read
   always_ff @(posedge clock) begin
      if (advance && fb_we) begin
         fb_ff[fb_idx] <= b;
      end
   end

endmodule

// File: sv/gsbp_rsp_stage.sv
// result register of the gif stream block parser
module gsbp_rsp_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   input  gsbp_pkg::rsp_type result,
   output logic              advance,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output gsbp_pkg::rsp_type rsp_data
);
   import gsbp_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   // the held request moves on when the result register is free
   assign advance  = item_valid & (~valid_ff | ~rsp_stall);
   assign valid_in = advance | (valid_ff & rsp_stall);

   // control register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload register
   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// File: sv/gif_stream_block_parser.sv
// top level of the gif stream block parser
//
//   channel  direction  ports                           moves
//   req      in         req_valid req_stall req_data    one file byte with first/last marks
//   rsp      out        rsp_valid rsp_stall rsp_data    one result per byte
//
// one byte per cycle while rsp_stall is low: a request goes through the input register,
// is decoded combinationally against the parse state and lands in the result register.
// an accepted request passes the input and result registers before its result is valid.
// reset clears the parse state and both valid flags; first_byte restarts a file.
// a stalled result holds the input register, which then stalls the request side.
module gif_stream_block_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  gsbp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output gsbp_pkg::rsp_type rsp_data
);
   import gsbp_pkg::*;

   logic    item_valid;
   logic    advance;
   req_type item;
   rsp_type result;

   // input register
   gsbp_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   // decode and parse state
   gsbp_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item),
      .result  (result)
   );

   // result register
   gsbp_rsp_stage u_rsp_stage (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .result     (result),
      .advance    (advance),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

// File: dv/gsbp_checker.sv
// checker for the gif stream block parser: follows both channels and compares results
module gsbp_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  gsbp_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  gsbp_pkg::rsp_type rsp_data,
   output int                errors,
   output int                decoded_left
);
   import gsbp_pkg::*;

   // signature bytes, with the alternative version digit
   localparam logic [47:0] GIF_SIG87 = "GIF87a";
   localparam logic [7:0]  VER_9     = "9";

   // own copy of the parse state
   phase_type   phase;
   logic [3:0]  pos;
   logic [8:0]  idx;
   logic [8:0]  n_entries;
   logic [7:0]  sub_left;
   logic [15:0] rgb_hi;
   logic [7:0]  fbytes [FIELD_DEPTH];
   logic        ver89;

   rsp_type decoded_q[$];
   int      err_tally;

   function automatic void clear_parse();
      phase     = PH_SIG;
      pos       = 4'd0;
      idx       = 9'd0;
      n_entries = 9'd0;
      sub_left  = 8'd0;
      rgb_hi    = 16'd0;
      ver89     = 1'b0;
      for (int i = 0; i < FIELD_DEPTH; i++) fbytes[i] = 8'd0;
   endfunction

   // little-endian word from the kept descriptor bytes
   function automatic logic [15:0] word_at(input int i);
      return {fbytes[i + 1], fbytes[i]};
   endfunction

   // three bytes make one colour entry; leave the table after the last one
   function automatic rsp_type colour_byte(input logic [7:0] b, input logic [3:0] kind,
                                           input phase_type after, input rsp_type o);
      rsp_type r;
      r = o;
      if (pos == 4'd0) begin
         rgb_hi = {b, 8'h00};
         pos    = 4'd1;
      end else if (pos == 4'd1) begin
         rgb_hi = {rgb_hi[15:8], b};
         pos    = 4'd2;
      end else begin
         r.kind    = kind;
         r.field_a = {7'd0, idx};
         r.color   = {rgb_hi, b};
         pos       = 4'd0;
         idx       = idx + 9'd1;
         if (idx >= n_entries) phase = after;
      end
      return r;
   endfunction

   // one file byte in, one result out
   function automatic rsp_type parse_gif_byte(input req_type r);
      rsp_type    o;
      logic [7:0] b;
      o = '0;
      b = r.data_byte;
      if (r.first_byte) clear_parse();
      case (phase)
         PH_SIG: begin
            if (pos == 4'd4 && b == VER_9) begin
               ver89 = 1'b1;
               pos   = pos + 4'd1;
            end else if (pos <= 4'd5 && b == GIF_SIG87[8 * (5 - pos) +: 8]) begin
               pos = pos + 4'd1;
            end else begin
               phase = PH_ERR;
            end
            if (phase == PH_SIG && pos == 4'd6) begin
               pos   = 4'd0;
               phase = PH_SCREEN;
            end
         end
         PH_SCREEN: begin
            fbytes[pos[2:0]] = b;
            if (pos < 4'd6) begin
               pos = pos + 4'd1;
            end else begin
               o.kind         = KIND_SCREEN;
               o.field_a      = word_at(0);
               o.field_b      = word_at(2);
               o.packed_flags = fbytes[4];
               o.aux_a        = fbytes[5];
               o.aux_b        = b;
               pos            = 4'd0;
               idx            = 9'd0;
               if (fbytes[4][7]) begin
                  n_entries = 9'd2 << fbytes[4][2:0];
                  phase     = PH_GCT;
               end else begin
                  n_entries = 9'd0;
                  phase     = PH_BLOCK;
               end
            end
         end
         PH_GCT: o = colour_byte(b, KIND_GLOBAL, PH_BLOCK, o);
         PH_BLOCK: begin
            pos = 4'd0;
            if (b == SEP_IMAGE) phase = PH_IDESC;
            else if (b == SEP_EXT) phase = PH_LABEL;
            else if (b == SEP_TRAILER && r.last_byte) phase = PH_FIN;
            else phase = PH_ERR;
         end
         PH_IDESC: begin
            fbytes[(pos < 4'd9) ? pos : 4'd8] = b;
            if (pos < 4'd8) begin
               pos = pos + 4'd1;
            end else begin
               o.kind         = KIND_IMAGE;
               o.field_a      = word_at(0);
               o.field_b      = word_at(2);
               o.field_c      = word_at(4);
               o.field_d      = word_at(6);
               o.packed_flags = b;
               pos            = 4'd0;
               idx            = 9'd0;
               if (b[7]) begin
                  n_entries = 9'd2 << b[2:0];
                  phase     = PH_LCT;
               end else begin
                  n_entries = 9'd0;
                  phase     = PH_CODESZ;
               end
            end
         end
         PH_LCT: o = colour_byte(b, KIND_LOCAL, PH_CODESZ, o);
         PH_CODESZ: begin
            o.kind    = KIND_CODE_SIZE;
            o.field_a = {8'd0, b};
            phase     = PH_DSIZE;
         end
         PH_DSIZE: begin
            if (b == 8'd0) begin
               o.kind = KIND_IMAGE_END;
               phase  = PH_BLOCK;
            end else begin
               sub_left = b;
               phase    = PH_DATA;
            end
         end
         PH_DATA: begin
            o.kind    = KIND_DATA;
            o.field_a = {8'd0, b};
            sub_left  = sub_left - 8'd1;
            if (sub_left == 8'd0) phase = PH_DSIZE;
         end
         PH_LABEL: begin
            pos = 4'd0;
            if (b == LBL_GRAPHIC) phase = PH_GCE;
            else if (b == LBL_COMMENT) phase = PH_SUBSIZE;
            else if (b == LBL_PLAINTEXT) phase = PH_PTSIZE;
            else if (b == LBL_APP) phase = PH_APPSIZE;
            else phase = PH_ERR;
         end
         PH_GCE: begin
            if (pos == 4'd0 && b != SIZE_GRAPHIC) begin
               phase = PH_ERR;
            end else if (pos < 4'd5) begin
               fbytes[pos] = b;
               pos         = pos + 4'd1;
            end else if (b != 8'd0) begin
               phase = PH_ERR;
            end else begin
               o.kind         = KIND_GRAPHIC;
               o.field_a      = word_at(2);
               o.packed_flags = fbytes[1];
               o.aux_a        = fbytes[4];
               pos            = 4'd0;
               phase          = PH_BLOCK;
            end
         end
         PH_PTSIZE, PH_APPSIZE: begin
            if (b != ((phase == PH_PTSIZE) ? SIZE_PLAINTEXT : SIZE_APP)) begin
               phase = PH_ERR;
            end else begin
               sub_left = b;
               phase    = PH_HDRSKIP;
            end
         end
         PH_HDRSKIP, PH_SUBSKIP: begin
            sub_left = sub_left - 8'd1;
            if (sub_left == 8'd0) phase = PH_SUBSIZE;
         end
         PH_SUBSIZE: begin
            if (b == 8'd0) begin
               phase = PH_BLOCK;
            end else begin
               sub_left = b;
               phase    = PH_SUBSKIP;
            end
         end
         default: ;
      endcase

      // status follows the phase; a last byte mid-file truncates
      if (phase == PH_FIN) begin
         o.status = ST_FINISHED;
      end else if (phase == PH_ERR) begin
         o.status = ST_FORMAT;
      end else if (phase == PH_TRUNC) begin
         o.status = ST_TRUNC;
      end else if (r.last_byte) begin
         phase    = PH_TRUNC;
         o.status = ST_TRUNC;
      end else begin
         o.status = ST_RUNNING;
      end
      o.is_89a = ver89;
      return o;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         err_tally++;
      end
   endfunction

   // compare results first, then queue the outcome of a new request
   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         clear_parse();
         decoded_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (decoded_q.size() == 0) begin
               $error("result with no request waiting: kind %0d", rsp_data.kind);
               err_tally++;
            end else begin
               want = decoded_q.pop_front();
               check_field("kind", want.kind, rsp_data.kind);
               check_field("field_a", want.field_a, rsp_data.field_a);
               check_field("field_b", want.field_b, rsp_data.field_b);
               check_field("field_c", want.field_c, rsp_data.field_c);
               check_field("field_d", want.field_d, rsp_data.field_d);
               check_field("color", want.color, rsp_data.color);
               check_field("packed_flags", want.packed_flags, rsp_data.packed_flags);
               check_field("aux_a", want.aux_a, rsp_data.aux_a);
               check_field("aux_b", want.aux_b, rsp_data.aux_b);
               check_field("is_89a", want.is_89a, rsp_data.is_89a);
               check_field("status", want.status, rsp_data.status);
            end
         end
         if (req_valid && !req_stall) decoded_q.push_back(parse_gif_byte(req_data));
      end
      errors       <= err_tally;
      decoded_left <= decoded_q.size();
   end

endmodule

// File: dv/tb.sv
// testbench top: builds gif byte streams, drives the parser and gives the verdict
module tb;
   import gsbp_pkg::*;

   localparam int          CYCLE_LIMIT = 1000000;
   localparam int          ITEM_GOAL   = 1200;
   localparam logic [47:0] GIF_SIG87   = "GIF87a";
   localparam logic [7:0]  VER_9       = "9";
   localparam logic [7:0]  BLOCK_END   = 8'h00;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;
   int      errors;
   int      decoded_left;

   req_type stream_q[$];
   int      sent;
   int      cycles;
   bit      no_idle;

   gif_stream_block_parser u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   gsbp_checker u_check (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .errors       (errors),
      .decoded_left (decoded_left)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // mostly short idle stretches, now and then a long one
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void put_byte(input logic [7:0] b);
      stream_q.push_back({b, 1'b0, 1'b0});
   endfunction

   function automatic void put_random(input int n);
      repeat (n) put_byte(8'($urandom));
   endfunction

   function automatic void put_sig(input bit ver89);
      for (int k = 0; k < 6; k++)
         put_byte((k == 4 && ver89) ? VER_9 : GIF_SIG87[8 * (5 - k) +: 8]);
   endfunction

   // packed flags with a random table bit; table sizes are mostly small
   function automatic logic [7:0] table_flags();
      logic [7:0] f;
      f = 8'($urandom);
      if ($urandom_range(0, 19) != 0) f[2:0] = 3'($urandom_range(0, 2));
      return f;
   endfunction

   function automatic void put_table(input logic [7:0] f);
      if (f[7]) put_random(3 * (2 << f[2:0]));
   endfunction

   function automatic void put_subblocks(input int n);
      int len;
      repeat (n) begin
         len = ($urandom_range(0, 29) == 0) ? 255 : $urandom_range(1, 16);
         put_byte(8'(len));
         put_random(len);
      end
      put_byte(BLOCK_END);
   endfunction

   // send every request of the stream, idling in front of some of them
   task automatic send_stream();
      int gap;
      foreach (stream_q[i]) begin
         gap = no_idle ? 0 : idle_len();
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_data  <= stream_q[i];
         @(posedge clock);
         while (req_stall) @(posedge clock);
         sent++;
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (decoded_left != 0);
   endtask

   // result side stalls in runs, with some long free stretches
   initial begin
      int n;
      rsp_stall <= 1'b0;
      forever begin
         n = idle_len();
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         repeat (($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 12)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   initial begin
      logic [7:0] flags;
      logic [7:0] hdr;
      int         base;
      int         cut;
      bit         app;
      req_valid <= 1'b0;
      req_data  <= '0;
      reset     <= 1'b1;
      sent      = 0;
      no_idle   = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // 87a file, screen fields at their extremes, no table, then the trailer
      put_sig(1'b0);
      put_byte(8'hFF);
      put_byte(8'hFF);
      put_byte(8'h00);
      put_byte(8'h00);
      put_byte(8'h7F);
      put_byte(8'hFF);
      put_byte(8'h00);
      put_byte(SEP_TRAILER);
      stream_q[0].first_byte = 1'b1;
      stream_q[$].last_byte  = 1'b1;
      // bad signature byte, then a byte after the error
      base = stream_q.size();
      put_byte(GIF_SIG87[47:40]);
      put_byte(GIF_SIG87[39:32]);
      put_byte(8'h58);
      put_byte(SEP_TRAILER);
      stream_q[base].first_byte = 1'b1;
      // one-byte truncated file, then a byte after the truncation
      base = stream_q.size();
      put_byte(GIF_SIG87[47:40]);
      put_byte(8'hA5);
      stream_q[base].first_byte = 1'b1;
      stream_q[base].last_byte  = 1'b1;
      send_stream();
      drain_results();

      // random files, mostly well formed, some cut short, corrupted or noise
      while (sent < ITEM_GOAL) begin
         stream_q.delete();
         no_idle = ($urandom_range(0, 3) == 0);
         put_sig($urandom_range(0, 1) == 1);
         put_random(4);
         flags = table_flags();
         put_byte(flags);
         put_random(2);
         put_table(flags);
         repeat ($urandom_range(0, 4)) begin
            case ($urandom_range(0, 5))
               0, 1: begin
                  put_byte(SEP_IMAGE);
                  put_random(8);
                  flags = table_flags();
                  put_byte(flags);
                  put_table(flags);
                  put_byte(8'($urandom));
                  put_subblocks($urandom_range(0, 3));
               end
               2: begin
                  put_byte(SEP_EXT);
                  put_byte(LBL_GRAPHIC);
                  put_byte(($urandom_range(0, 9) == 0) ? 8'($urandom) : SIZE_GRAPHIC);
                  put_random(4);
                  put_byte(($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : BLOCK_END);
               end
               3: begin
                  put_byte(SEP_EXT);
                  put_byte(($urandom_range(0, 19) == 0) ? 8'($urandom) : LBL_COMMENT);
                  put_subblocks($urandom_range(0, 3));
               end
               default: begin
                  app = ($urandom_range(0, 1) == 1);
                  put_byte(SEP_EXT);
                  put_byte(app ? LBL_APP : LBL_PLAINTEXT);
                  hdr = app ? SIZE_APP : SIZE_PLAINTEXT;
                  if ($urandom_range(0, 9) == 0) hdr = 8'($urandom);
                  put_byte(hdr);
                  put_random(hdr);
                  put_subblocks($urandom_range(0, 2));
               end
            endcase
         end
         put_byte(SEP_TRAILER);
         stream_q[0].first_byte = 1'b1;
         stream_q[$].last_byte  = 1'b1;

         case ($urandom_range(0, 9))
            // file cut short
            6: begin
               cut = $urandom_range(1, stream_q.size() - 1);
               while (stream_q.size() > cut) void'(stream_q.pop_back());
               stream_q[$].last_byte = 1'b1;
            end
            // one byte overwritten
            7: begin
               cut = $urandom_range(0, stream_q.size() - 1);
               stream_q[cut].data_byte = 8'($urandom);
            end
            // trailer that is not the last byte
            8: begin
               stream_q[$].last_byte = 1'b0;
               if ($urandom_range(0, 1) == 1) begin
                  put_random($urandom_range(1, 3));
                  stream_q[$].last_byte = 1'b1;
               end
            end
            // plain noise with random marks
            9: begin
               stream_q.delete();
               repeat ($urandom_range(1, 20)) begin
                  put_byte(8'($urandom));
                  stream_q[$].first_byte = ($urandom_range(0, 3) == 0);
                  stream_q[$].last_byte  = ($urandom_range(0, 7) == 0);
               end
            end
            default: ;
         endcase
         send_stream();
         if ($urandom_range(0, 15) == 0) drain_results();
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (errors == 0 && decoded_left == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
